/* rtl/core/sdeu_pkg.sv */
// Shared types and constants for the digitizer event unroller.
package sdeu_pkg;

  // Default geometry of the digitizer and the spectrum pool
  localparam int unsigned CELL_COUNT_DEF     = 2560;
  localparam int unsigned KEPT_SAMPLES_DEF   = 2048;
  localparam int unsigned SPECTRUM_SLOTS_DEF = 2048;

  // Block layout
  localparam int unsigned HEADER_WORDS = 16;
  localparam int unsigned LANES        = 4;
  localparam int unsigned COLUMNS      = 128;
  localparam int unsigned COLUMN_CELLS = 20;

  localparam int unsigned POS_W = 14;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int unsigned END_CELL_W = 12;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_SLOT_NUMBER = 1'b0;

  // Lane order on the board has its halves swapped: lanes 0,1 feed channels 2,3
  localparam logic [1:0] LANE_TO_CHANNEL [LANES] = '{2'd2, 2'd3, 2'd0, 2'd1};

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_CLEAR_CUR = 2'd1,
    KIND_CLEAR_ALL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_EVENT  = 2'd0,
    CMD_COLUMN = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [15:0] word;
    logic        block_start;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [10:0] spectrum_index;
    logic [1:0]  channel;
    logic [10:0] bin;
    logic [15:0] value;
    logic        last;
  } out_t;

  // Work handed from the classifier to the executor
  typedef struct packed {
    cmd_e             op;
    logic [POS_W-1:0] rel;   // word position minus header, for samples
    logic [15:0]      word;
  } cmd_t;

endpackage

/* rtl/core/sdeu_front.sv */
// Front end: tracks the word position and classifies each word into a command.
module sdeu_front #(
  parameter int unsigned CELL_COUNT = sdeu_pkg::CELL_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sdeu_pkg::in_t  in_data_i,
  input  logic           full_i,
  output logic           push_o,
  output sdeu_pkg::cmd_t push_data_o
);
  import sdeu_pkg::*;

  localparam int unsigned SAMPLE_END = HEADER_WORDS + LANES * CELL_COUNT;

  logic [POS_W-1:0] pos_q, pos_d, pos;
  logic             ev_q, ev_d;
  logic             accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign pos        = in_data_i.block_start ? '0 : pos_q;

  always_comb begin
    pos_d       = pos_q;
    ev_d        = ev_q;
    push_o      = 1'b0;
    push_data_o = '{op: CMD_EVENT, rel: '0, word: in_data_i.word};
    if (accept && (pos != POS_MAX)) begin
      pos_d = pos + POS_W'(1);
      if (pos == '0) begin
        ev_d   = in_data_i.word[0];
        push_o = in_data_i.word[0];
      end else if (pos == POS_W'(2)) begin
        push_o         = 1'b1;
        push_data_o.op = CMD_COLUMN;
      end else if ((pos >= POS_W'(HEADER_WORDS)) && (32'(pos) < SAMPLE_END) && ev_q) begin
        push_o          = 1'b1;
        push_data_o.op  = CMD_SAMPLE;
        push_data_o.rel = pos - POS_W'(HEADER_WORDS);
      end
    end else if (accept) begin
      // saturated position: word ignored, position holds
      pos_d = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ev_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ev_q  <= ev_d;
    end
  end

endmodule

/* rtl/core/sdeu_queue.sv */
// Short command queue between the front end and the executor.
module sdeu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdeu_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           head_valid_o,
  output sdeu_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import sdeu_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/sdeu_back.sv */
// Back end: executes commands, keeps end cell and spectrum slot, drives results.
module sdeu_back #(
  parameter int unsigned CELL_COUNT     = sdeu_pkg::CELL_COUNT_DEF,
  parameter int unsigned KEPT_SAMPLES   = sdeu_pkg::KEPT_SAMPLES_DEF,
  parameter int unsigned SPECTRUM_SLOTS = sdeu_pkg::SPECTRUM_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  sdeu_pkg::cmd_t head_i,
  output logic           pop_o,
  input  logic [7:0]     slot_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sdeu_pkg::out_t out_data_o
);
  import sdeu_pkg::*;

  localparam int unsigned SPEC_W = (SPECTRUM_SLOTS > 1) ? $clog2(SPECTRUM_SLOTS) : 1;
  // raw end cell stays below 4096, so the quotient by CELL_COUNT >= 128 fits 5 bits
  localparam int unsigned MOD_STEPS = 5;
  localparam int unsigned RAW_W = 17;

  logic [END_CELL_W-1:0] end_q, end_d;
  logic [SPEC_W-1:0]     spec_q, spec_d;
  logic [SPEC_W:0]       nx;
  logic                  wrap;
  logic                  started_q, started_d;
  logic                  phase_q, phase_d;   // clear-all sent, clear-current pending
  logic                  out_valid_q, can_out, emit;
  out_t                  out_q, res;

  logic [7:0]            col_span;
  logic [RAW_W-1:0]      rem;
  logic [END_CELL_W-1:0] cell_idx;
  logic [1:0]            lane;
  logic [END_CELL_W:0]   bin_w;
  logic                  keep;

  assign can_out     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign nx   = {1'b0, spec_q} + (SPEC_W + 1)'(1);
  assign wrap = (nx >= (SPEC_W + 1)'(SPECTRUM_SLOTS));

  // end cell = (20*(128 - column) + slot + 1) mod CELL_COUNT, by restoring subtracts
  assign col_span = 8'(COLUMNS) - {1'b0, head_i.word[6:0]};
  always_comb begin
    rem = RAW_W'(col_span) * RAW_W'(COLUMN_CELLS) + RAW_W'(slot_i) + RAW_W'(1);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (rem >= RAW_W'(CELL_COUNT << k)) begin
        rem = rem - RAW_W'(CELL_COUNT << k);
      end
    end
  end

  assign cell_idx = head_i.rel[POS_W-1:2];
  assign lane     = head_i.rel[1:0];
  assign bin_w    = (cell_idx >= end_q) ? {1'b0, cell_idx - end_q}
                  : {1'b0, cell_idx} + (END_CELL_W + 1)'(CELL_COUNT) - {1'b0, end_q};
  assign keep     = (bin_w < (END_CELL_W + 1)'(KEPT_SAMPLES));

  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    end_d     = end_q;
    spec_d    = spec_q;
    started_d = started_q;
    phase_d   = phase_q;
    res       = '0;
    res.spectrum_index = 11'(spec_q);
    res.last  = 1'b1;
    if (head_valid_i) begin
      case (head_i.op)
        CMD_COLUMN: begin
          pop_o = 1'b1;
          end_d = rem[END_CELL_W-1:0];
        end
        CMD_SAMPLE: begin
          if (keep) begin
            emit        = 1'b1;
            pop_o       = can_out;
            res.kind    = KIND_WRITE;
            res.channel = LANE_TO_CHANNEL[lane];
            res.bin     = bin_w[10:0];
            res.value   = head_i.word;
          end else begin
            pop_o = 1'b1;
          end
        end
        CMD_EVENT: begin
          emit     = 1'b1;
          res.kind = KIND_CLEAR_CUR;
          if (can_out) begin
            if (!started_q) begin
              started_d          = 1'b1;
              spec_d             = '0;
              res.spectrum_index = '0;
              pop_o              = 1'b1;
            end else if (phase_q) begin
              phase_d = 1'b0;
              pop_o   = 1'b1;
            end else if (wrap) begin
              spec_d             = '0;
              phase_d            = 1'b1;
              res.kind           = KIND_CLEAR_ALL;
              res.spectrum_index = '0;
              res.last           = 1'b0;
            end else begin
              spec_d             = nx[SPEC_W-1:0];
              res.spectrum_index = 11'(nx[SPEC_W-1:0]);
              pop_o              = 1'b1;
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && can_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q       <= '0;
      spec_q      <= '0;
      started_q   <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      end_q     <= end_d;
      spec_q    <= spec_d;
      started_q <= started_d;
      phase_q   <= phase_d;
      if (can_out) begin
        out_valid_q <= emit;
      end
    end
  end

endmodule

/* rtl/core/sca_digitizer_event_unroller.sv */
// Digitizer event unroller: one input word per cycle; the front end tracks the
// word position and classifies each word, a four-entry command queue decouples
// it from the executor, which realigns samples to trigger-relative bins and
// issues spectrum clears. Sustained rate is one word per cycle unless the queue
// fills or the output stalls; an event header that wraps the spectrum slot gives
// two results, which the queue absorbs. An accepted word's result is registered
// in a queue entry, then in the output register. No clearing pass after reset.
// The slot number register sits at byte address 0 of the APB port.
module sca_digitizer_event_unroller #(
  parameter int unsigned CELL_COUNT     = sdeu_pkg::CELL_COUNT_DEF,
  parameter int unsigned KEPT_SAMPLES   = sdeu_pkg::KEPT_SAMPLES_DEF,
  parameter int unsigned SPECTRUM_SLOTS = sdeu_pkg::SPECTRUM_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sdeu_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sdeu_pkg::out_t                  out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdeu_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sdeu_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sdeu_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import sdeu_pkg::*;

  logic [7:0] slot_q;
  logic       push, full, head_valid, pop;
  cmd_t       push_data, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLOT_NUMBER) ? APB_DATA_W'(slot_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLOT_NUMBER)) begin
      slot_q <= pwdata[7:0];
    end
  end

  sdeu_front #(
    .CELL_COUNT(CELL_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  sdeu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  sdeu_back #(
    .CELL_COUNT    (CELL_COUNT),
    .KEPT_SAMPLES  (KEPT_SAMPLES),
    .SPECTRUM_SLOTS(SPECTRUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .slot_i      (slot_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/sv/sca_digitizer_event_unroller_tb.sv */
// Self-checking testbench for the digitizer event unroller.
module sca_digitizer_event_unroller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdeu_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] word;
    logic        block_start;
    logic [4:0]  count;
    logic        typed;
    out_t        op;
  } stim_row_t;

  // Slot number is at its reset value (0) for the directed rows.
  // Column 0x66 gives end cell 521, so cell 0 lands in bin 2039.
  localparam stim_row_t DIRECTED [10] = '{
    '{16'hFFFF, 1'b0, 5'd1, 1'b1, '{KIND_CLEAR_CUR, 11'd0, 2'd0, 11'd0, 16'd0, 1'b1}},
    '{16'h0000, 1'b0, 5'd1, 1'b0, '0},
    '{16'hFF66, 1'b0, 5'd1, 1'b0, '0},
    '{16'h5555, 1'b0, 5'd13, 1'b0, '0},
    '{16'h0000, 1'b0, 5'd1, 1'b0, '0},
    '{16'hFFFF, 1'b0, 5'd1, 1'b0, '0},
    '{16'h8000, 1'b0, 5'd1, 1'b0, '0},
    '{16'h7FFF, 1'b0, 5'd1, 1'b0, '0},
    '{16'h0000, 1'b1, 5'd1, 1'b0, '0},
    '{16'h0003, 1'b1, 5'd1, 1'b1, '{KIND_CLEAR_CUR, 11'd1, 2'd0, 11'd0, 16'd0, 1'b1}}
  };

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state
  logic [POS_W-1:0] word_pos        = '0;
  logic             event_live      = 1'b0;
  int unsigned      trig_end        = 0;
  int unsigned      cur_spectrum    = 0;
  logic             spectrum_chosen = 1'b0;
  logic [7:0]       slot_reg        = '0;

  out_t        expected_ops[$];
  out_t        head_op;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  sca_digitizer_event_unroller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Works out the spectrum commands caused by one word and queues them.
  function automatic void unroll_word(input logic [15:0] w, input logic bs);
    logic [POS_W-1:0] pos;
    int unsigned      rel;
    int unsigned      bin;
    out_t             op;
    op = '0;
    if (bs) word_pos = '0;
    pos = word_pos;
    if (pos == POS_MAX) return;
    word_pos = pos + 1'b1;
    if (pos == 0) begin
      event_live = w[0];
      if (event_live) begin
        if (!spectrum_chosen) begin
          spectrum_chosen = 1'b1;
          cur_spectrum = 0;
        end else if (cur_spectrum + 1 >= SPECTRUM_SLOTS_DEF) begin
          cur_spectrum = 0;
          op.kind = KIND_CLEAR_ALL;
          expected_ops.push_back(op);
        end else begin
          cur_spectrum++;
        end
        op.kind = KIND_CLEAR_CUR;
        op.spectrum_index = 11'(cur_spectrum);
        op.last = 1'b1;
        expected_ops.push_back(op);
      end
    end else if (pos == 2) begin
      trig_end = (COLUMN_CELLS * (COLUMNS - w[6:0]) + slot_reg + 1) % CELL_COUNT_DEF;
    end else if (pos >= HEADER_WORDS && pos < HEADER_WORDS + LANES * CELL_COUNT_DEF
                 && event_live) begin
      rel = pos - HEADER_WORDS;
      bin = (rel / LANES + CELL_COUNT_DEF - trig_end) % CELL_COUNT_DEF;
      if (bin < KEPT_SAMPLES_DEF) begin
        op.kind = KIND_WRITE;
        op.spectrum_index = 11'(cur_spectrum);
        op.channel = LANE_TO_CHANNEL[rel % LANES];
        op.bin = 11'(bin);
        op.value = w;
        op.last = 1'b1;
        expected_ops.push_back(op);
      end
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input logic [15:0] w, input logic bs, input logic typed,
                           input out_t typed_op);
    int unsigned known;
    while (!no_idle && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {w, bs};
    do @(posedge clk_i); while (in_stall_o);
    known = expected_ops.size();
    unroll_word(w, bs);
    if (typed) begin
      while (expected_ops.size() > known) void'(expected_ops.pop_back());
      expected_ops.push_back(typed_op);
    end
  endtask

  task automatic send_plain(input logic [15:0] w, input logic bs);
    send_word(w, bs, 1'b0, '0);
  endtask

  // Block goes quiet; words that cause no result may still be in the queue.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_ops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_slot(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(REG_SLOT_NUMBER) << 2;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    slot_reg = value;
  endtask

  // Mostly well-formed short blocks with random content, some noise.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [15:0] w;
    logic        bs;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) send_plain(16'($urandom), $urandom_range(7) == 0);
      end else begin
        len = HEADER_WORDS + $urandom_range(0, 48);
        for (int i = 0; i < len; i++) begin
          w  = 16'($urandom);
          bs = (i == 0);
          if (i == 0) w[0] = $urandom_range(99) < 85;
          if ($urandom_range(199) == 0) bs = ~bs;  // lost or spurious block start
          send_plain(w, bs);
        end
      end
      sent += len;
    end
  endtask

  always @(posedge clk_i) out_stall_i <= !no_idle && ($urandom_range(99) < 36);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ops.size() == 0) begin
        $display("%0t: expected no transaction, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        head_op = expected_ops.pop_front();
        check_field("kind", head_op.kind, out_data_o.kind);
        check_field("spectrum_index", head_op.spectrum_index, out_data_o.spectrum_index);
        check_field("channel", head_op.channel, out_data_o.channel);
        check_field("bin", head_op.bin, out_data_o.bin);
        check_field("value", head_op.value, out_data_o.value);
        check_field("last", head_op.last, out_data_o.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < $size(DIRECTED); r++)
      repeat (DIRECTED[r].count)
        send_word(DIRECTED[r].word, DIRECTED[r].block_start, DIRECTED[r].typed,
                  DIRECTED[r].op);
    settle();

    set_slot(8'hFF);
    random_traffic(370);
    settle();

    set_slot(8'($urandom));
    no_idle = 1'b1;
    random_traffic(370);
    no_idle = 1'b0;
    settle();

    set_slot(8'h00);
    random_traffic(370);
    settle();

    if (mismatches == 0 && expected_ops.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (expected_ops.size() != 0)
        $display("%0t: %0d expected transactions never arrived", $time, expected_ops.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sdeu_pkg.sv
rtl/core/sdeu_front.sv
rtl/core/sdeu_queue.sv
rtl/core/sdeu_back.sv
rtl/core/sca_digitizer_event_unroller.sv
tb/sv/sca_digitizer_event_unroller_tb.sv
